@@ src/merkle_path_fold_sha256_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Merkle path fold block
// Shared concurrent assertion forms, reported by $error.
// ----------------------------------------------------------------------------
`ifndef MERKLE_PATH_FOLD_SHA256_DEFINES_SVH
`define MERKLE_PATH_FOLD_SHA256_DEFINES_SVH

// cond implies prop on the same edge
`define MPF_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// cond implies prop on the next edge
`define MPF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ src/mpf_pkg.sv @@
// ----------------------------------------------------------------------------
// mpf_pkg
// Constants, tables and round functions for the SHA-256 Merkle path fold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpf_pkg;

   localparam int MAX_PATH_DEFAULT = 64;
   localparam int ROUNDS = 64;
   localparam int CNT_W = 8;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INIT = 5'b00010,
      ST_RND  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   localparam logic [255:0] H_INIT = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ src/merkle_path_fold_sha256.sv @@
// ----------------------------------------------------------------------------
// merkle_path_fold_sha256
// Folds a Merkle inclusion path into a leaf digest with SHA-256.
// ----------------------------------------------------------------------------
// A start word (mode 0) loads the leaf digest; it is accepted in idle, passes
// one output step and the block is then ready again. A path word (mode 1)
// runs two SHA-256 compressions on one round unit, one round per cycle: a
// load step, 64 rounds and an add step per block, then one output step, so
// no new path word is accepted until the fold is through; req_ready is low
// meanwhile. A path word past MAX_PATH or after an overflow passes only the
// output step, like a start word. Words with last set give one result on
// rsp_, held in an output register until taken; a new word is accepted while
// it waits, and only a following result stalls in the output step until the
// held one is taken.
`timescale 1ns / 1ps

module merkle_path_fold_sha256 #(
   parameter int MAX_PATH = mpf_pkg::MAX_PATH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic        req_on_left,
   input  logic [63:0] req_digest_word0,
   input  logic [63:0] req_digest_word1,
   input  logic [63:0] req_digest_word2,
   input  logic [63:0] req_digest_word3,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_root_word0,
   output logic [63:0] rsp_root_word1,
   output logic [63:0] rsp_root_word2,
   output logic [63:0] rsp_root_word3,
   output logic        rsp_too_long
);

`include "merkle_path_fold_sha256_defines.svh"

   localparam int CW = mpf_pkg::CNT_W;

   mpf_pkg::state_type state_ff, state_in;
   logic [255:0] dig_ff, dig_in;
   logic [511:0] blk_ff, blk_in;
   logic [255:0] hc_ff, hc_in;
   logic [255:0] v_ff, v_in;
   logic [511:0] w_ff, w_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         blk2_ff, blk2_in;
   logic         last_ff, last_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic         ovf_ff, ovf_in;
   logic         rv_ff, rv_in;
   logic [255:0] root_ff, root_in;
   logic         tl_ff, tl_in;

   logic req_acc, rsp_acc;
   logic [255:0] req_dig;
   logic [31:0] a, b, c, d, e, f, g, h, wt, w2, w15, w7, w16, s0, s1, t1, t2;
   logic [255:0] hsum;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rv_ff && rsp_ready;
   assign req_ready = (state_ff == mpf_pkg::ST_IDLE);
   assign req_dig = {req_digest_word0, req_digest_word1, req_digest_word2,
                     req_digest_word3};

   // round unit; w_ff holds the 16-word window, word 0 at the top
   assign {a, b, c, d, e, f, g, h} = v_ff;
   assign w16 = w_ff[511:480];
   assign w15 = w_ff[479:448];
   assign w7  = w_ff[223:192];
   assign w2  = w_ff[63:32];
   assign s0 = mpf_pkg::rotr(w15, 7) ^ mpf_pkg::rotr(w15, 18) ^ (w15 >> 3);
   assign s1 = mpf_pkg::rotr(w2, 17) ^ mpf_pkg::rotr(w2, 19) ^ (w2 >> 10);
   assign wt = w16;
   assign t1 = h + (mpf_pkg::rotr(e, 6) ^ mpf_pkg::rotr(e, 11) ^ mpf_pkg::rotr(e, 25))
             + ((e & f) ^ (~e & g)) + mpf_pkg::round_k(rnd_ff) + wt;
   assign t2 = (mpf_pkg::rotr(a, 2) ^ mpf_pkg::rotr(a, 13) ^ mpf_pkg::rotr(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hsum[i*32 +: 32] = hc_ff[i*32 +: 32] + v_ff[i*32 +: 32];
      end
   end

   always_comb begin
      state_in = state_ff;
      dig_in = dig_ff;
      blk_in = blk_ff;
      hc_in = hc_ff;
      v_in = v_ff;
      w_in = w_ff;
      rnd_in = rnd_ff;
      blk2_in = blk2_ff;
      last_in = last_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      rv_in = rv_ff && !rsp_ready;
      root_in = root_ff;
      tl_in = tl_ff;
      case (state_ff)
         mpf_pkg::ST_IDLE: begin
            if (req_acc) begin
               last_in = req_last;
               if (!req_mode) begin
                  dig_in = req_dig;
                  cnt_in = '0;
                  ovf_in = 1'b0;
                  state_in = mpf_pkg::ST_OUT;
               end else if (ovf_ff || (32'(cnt_ff) >= 32'(MAX_PATH))) begin
                  ovf_in = 1'b1;
                  state_in = mpf_pkg::ST_OUT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  blk_in = req_on_left ? {req_dig, dig_ff} : {dig_ff, req_dig};
                  hc_in = mpf_pkg::H_INIT;
                  blk2_in = 1'b0;
                  state_in = mpf_pkg::ST_INIT;
               end
            end
         end
         mpf_pkg::ST_INIT: begin
            v_in = hc_ff;
            w_in = blk_ff;
            rnd_in = '0;
            state_in = mpf_pkg::ST_RND;
         end
         mpf_pkg::ST_RND: begin
            v_in = {t1 + t2, a, b, c, d + t1, e, f, g};
            w_in = {w_ff[479:0], s1 + w7 + s0 + w16};
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 6'(mpf_pkg::ROUNDS - 1)) begin
               state_in = mpf_pkg::ST_ADD;
            end
         end
         mpf_pkg::ST_ADD: begin
            if (!blk2_ff) begin
               hc_in = hsum;
               blk_in = {32'h80000000, 448'h0, 32'd512};
               blk2_in = 1'b1;
               state_in = mpf_pkg::ST_INIT;
            end else begin
               dig_in = hsum;
               state_in = mpf_pkg::ST_OUT;
            end
         end
         mpf_pkg::ST_OUT: begin
            // hold a result step while the previous result is still waiting
            if (!(last_ff && rv_ff && !rsp_ready)) begin
               state_in = mpf_pkg::ST_IDLE;
               if (last_ff) begin
                  rv_in = 1'b1;
                  root_in = ovf_ff ? '0 : dig_ff;
                  tl_in = ovf_ff;
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: state_in = mpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpf_pkg::ST_IDLE;
         dig_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         rv_ff <= 1'b0;
         rnd_ff <= '0;
      end else begin
         state_ff <= state_in;
         dig_ff <= dig_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         rv_ff <= rv_in;
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      hc_ff <= hc_in;
      v_ff <= v_in;
      w_ff <= w_in;
      blk2_ff <= blk2_in;
      last_ff <= last_in;
      root_ff <= root_in;
      tl_ff <= tl_in;
   end

   assign rsp_valid = rv_ff;
   assign {rsp_root_word0, rsp_root_word1, rsp_root_word2, rsp_root_word3} = root_ff;
   assign rsp_too_long = tl_ff;

   `MPF_ASSERT_IMPL(a_tl_zero_root, clock, reset, rsp_valid && rsp_too_long, rsp_root_word0 == 64'h0 && rsp_root_word3 == 64'h0, "overflow result carries a root")
   `MPF_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, 32'(cnt_ff) <= 32'(MAX_PATH), "element count above limit")
   `MPF_ASSERT_NEXT(a_busy_after_fold, clock, reset, req_acc && req_mode && !ovf_ff && 32'(cnt_ff) < 32'(MAX_PATH), !req_ready, "ready during fold")

endmodule
